[rtl/resonant_bandpass_filter_macros.svh]
// ----------------------------------------------------------------------------
// Resonant bandpass filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef RESONANT_BANDPASS_FILTER_MACROS_SVH
`define RESONANT_BANDPASS_FILTER_MACROS_SVH

// same-cycle implication
`define RBF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rbf_pkg.sv]
// ----------------------------------------------------------------------------
// Resonant bandpass filter package
// Shared constants, sequencer states, unit interfaces and helper functions.
// ----------------------------------------------------------------------------
package rbf_pkg;

  localparam int DEFAULT_TABLE_SIZE   = 512;
  localparam int DEFAULT_SAMPLE_WIDTH = 24;

  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 50;
  localparam int DIV_Q_W   = 32;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_FACTOR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd1;

  localparam logic [31:0] SP_RESET  = 32'd89478;
  localparam logic [17:0] AMP_RESET = 18'd65536;
  localparam logic [17:0] AMP_ONE   = 18'h20000;
  localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
  localparam int TAYLOR_TERMS = 12;
  localparam int TAB_READS    = 4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AMP_DIV,
    ST_PS_MUL,
    ST_PS_DIV,
    ST_DEC_MUL,
    ST_PHASE_MUL,
    ST_TAB_RD,
    ST_CI_MUL,
    ST_SI_MUL,
    ST_RC_MUL,
    ST_IC_MUL,
    ST_GAIN_MUL,
    ST_TERM_MUL,
    ST_RR_MUL,
    ST_II_MUL,
    ST_IR_MUL,
    ST_RI_MUL,
    ST_WB
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sh007FFFFFFF;
    lo = -hi - 40'sd1;
    if (v > hi) return 32'h7FFFFFFF;
    if (v < lo) return 32'h80000000;
    return v[31:0];
  endfunction

  // cos(2*pi*m/2^lg) in Q1.23 over one quadrant, Taylor series
  function automatic logic [23:0] quarter_cos(input logic [63:0] m, input int lg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x = (TWO_PI_Q29 * m * 64'd2 + (64'd1 << (lg - 1))) >> lg;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = signed'(term);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k & 1) != 0) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 64'sd0;
    r = (sum + 64'sd64) >>> 7;
    if (r > 64'sd8388607) r = 64'sd8388607;
    return r[23:0];
  endfunction

endpackage

[rtl/rbf_serial_mul.sv]
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Retires one multiplier bit per cycle; done rises when the product is ready.
// ----------------------------------------------------------------------------
module rbf_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  rbf_pkg::mul_req_t req,
  output rbf_pkg::mul_rsp_t rsp
);
  import rbf_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic signed [MUL_W-1:0] mcand;
  logic [MUL_W-1:0]        mplier;
  logic signed [MUL_W:0]   hi;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;
  logic                    done;
  logic signed [MUL_W+1:0] addend;
  logic signed [MUL_W+1:0] sum;
  logic                    last;

  assign last = (cnt == CNT_W'(MUL_W - 1));

  always_comb begin
    addend = '0;
    if (mplier[0]) begin
      addend = last ? -(MUL_W+2)'(mcand) : (MUL_W+2)'(mcand);
    end
    sum = (MUL_W+2)'(hi) + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= req.a;
      mplier <= req.b;
      hi     <= '0;
    end else if (busy) begin
      hi     <= sum[MUL_W+1:1];
      mplier <= {sum[0], mplier[MUL_W-1:1]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = PROD_W'({hi, mplier});

endmodule

[rtl/rbf_serial_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; expects the upper numerator half below den.
// ----------------------------------------------------------------------------
module rbf_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  rbf_pkg::div_req_t req,
  output rbf_pkg::div_rsp_t rsp
);
  import rbf_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_Q_W-1:0]   ql;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [DIV_DEN_W:0]   sh;
  logic                 qbit;
  logic [DIV_DEN_W-1:0] rem_next;

  always_comb begin
    sh = {rem, ql[DIV_Q_W-1]};
    qbit = (sh >= {1'b0, den});
    rem_next = qbit ? DIV_DEN_W'(sh - {1'b0, den}) : sh[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(DIV_Q_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= DIV_DEN_W'(req.num[DIV_NUM_W-1:DIV_Q_W]);
      ql  <= req.num[DIV_Q_W-1:0];
      den <= req.den;
    end else if (busy) begin
      rem <= rem_next;
      ql  <= {ql[DIV_Q_W-2:0], qbit};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = ql;

endmodule

[rtl/resonant_bandpass_filter.sv]
// ----------------------------------------------------------------------------
// Resonant bandpass filter
// Complex one-pole resonator with interpolated cosine lookup, fixed point.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry input_sample (Q1.23) and center_freq
// (Q16.8 Hz). Output channel: out_valid/out_stall carry real_out and imag_out.
// A transfer happens on a clock edge with valid high and stall low.
// Each item runs twelve multiplications on one bit-serial multiplier, plus
// the cosine ROM reads; in_stall stays high until the item leaves write-back,
// so a new item is taken only once the previous one is finished.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already taken and computed; the block only waits
// at write-back if the previous result is still held.
// A write to q_factor or sample_period (cfg_write, cfg_index, cfg_data)
// recomputes the gain and pole scale with the serial divider and
// multiplier while in_stall stays high.
// rst (synchronous) clears the filter state, loads q_factor = 0 and
// sample_period = 48 kHz, and leaves the block idle with no result pending.
// ----------------------------------------------------------------------------
module resonant_bandpass_filter #(
  parameter int TABLE_SIZE   = rbf_pkg::DEFAULT_TABLE_SIZE,
  parameter int SAMPLE_WIDTH = rbf_pkg::DEFAULT_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] input_sample,
  input  logic signed [24:0]             center_freq,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] real_out,
  output logic signed [SAMPLE_WIDTH-1:0] imag_out
);
  import rbf_pkg::*;

  `include "resonant_bandpass_filter_macros.svh"

  localparam int L      = $clog2(TABLE_SIZE);
  localparam int QN     = TABLE_SIZE / 4;
  localparam int QA_W   = L - 1;
  localparam int OUT_SH = 32 - SAMPLE_WIDTH;
  localparam logic signed [34:0] OUT_MAX = 35'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [34:0] OUT_MIN = -OUT_MAX - 35'sd1;

  typedef logic [23:0] qrom_t [QN+1];

  function automatic qrom_t build_qrom();
    qrom_t t;
    for (int m = 0; m <= QN; m++) begin
      t[m] = quarter_cos(64'(m), L);
    end
    return t;
  endfunction

  localparam qrom_t QROM = build_qrom();

  function automatic logic signed [SAMPLE_WIDTH-1:0] to_out(input logic signed [31:0] s);
    logic signed [34:0] w;
    w = (35'(s) <<< 3) >>> OUT_SH;
    if (w > OUT_MAX) w = OUT_MAX;
    if (w < OUT_MIN) w = OUT_MIN;
    return w[SAMPLE_WIDTH-1:0];
  endfunction

  state_t state, state_next;

  logic [31:0] q_factor;
  logic [31:0] sample_period;
  logic [17:0] amp;
  logic [31:0] pole_scale;
  logic [63:0] num;

  logic signed [SAMPLE_WIDTH-1:0] samp;
  logic [23:0] freq;
  logic [31:0] radius;
  logic [L-1:0] idx;
  logic [15:0] frac;
  logic signed [24:0] ta, tb, sa, sb;
  logic signed [24:0] ci, si;
  logic signed [31:0] rc, ic;
  logic [30:0] gain;
  logic signed [31:0] term;
  logic signed [PROD_W-1:0] acc;
  logic signed [31:0] nr;
  logic signed [31:0] rs, is;

  logic issued;
  logic op_start;
  logic is_mul, is_div, op_done, step;
  logic cfg_hit;
  logic ps_sat;
  logic [DIV_DEN_W-1:0] ps_den;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [PROD_W-1:0] prod;

  logic [2:0] rd_cnt;
  logic [L:0] rd_n;
  logic [L-1:0] idx2;
  logic [2:0] quad;
  logic [QA_W-1:0] rom_addr;
  logic rom_neg, neg_q;
  logic [23:0] rom_q;
  logic signed [24:0] rd_val;

  logic [51:0] dec;
  logic [32:0] inv_r;

  assign cfg_hit = cfg_write && (cfg_index == CFG_Q_FACTOR || cfg_index == CFG_SAMPLE_PERIOD);
  assign in_stall = (state != ST_IDLE) || cfg_write;
  assign prod = mrsp.prod;

  assign is_div = (state == ST_AMP_DIV) || (state == ST_PS_DIV);
  assign is_mul = state inside {ST_PS_MUL, ST_DEC_MUL, ST_PHASE_MUL, ST_CI_MUL, ST_SI_MUL,
                                ST_RC_MUL, ST_IC_MUL, ST_GAIN_MUL, ST_TERM_MUL, ST_RR_MUL,
                                ST_II_MUL, ST_IR_MUL, ST_RI_MUL};
  assign op_done = is_div ? drsp.done : mrsp.done;
  assign step = issued && op_done && (is_mul || is_div);

  assign ps_den = {1'b0, q_factor, 17'b0};
  assign ps_sat = ({18'b0, num[63:32]} >= ps_den);

  assign dec = prod[55:4];
  assign inv_r = 33'h100000000 - {1'b0, radius};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op_start = (is_mul || is_div) && !issued && !(state == ST_PS_DIV && ps_sat);
    case (state)
      ST_IDLE:      if (in_valid && !in_stall) state_next = ST_DEC_MUL;
      ST_AMP_DIV:   if (step) state_next = (q_factor == 32'd0) ? ST_IDLE : ST_PS_MUL;
      ST_PS_MUL:    if (step) state_next = ST_PS_DIV;
      ST_PS_DIV:    if (ps_sat || step) state_next = ST_IDLE;
      ST_DEC_MUL:   if (step) state_next = ST_PHASE_MUL;
      ST_PHASE_MUL: if (step) state_next = ST_TAB_RD;
      ST_TAB_RD:    if (rd_cnt == 3'(TAB_READS)) state_next = ST_CI_MUL;
      ST_CI_MUL:    if (step) state_next = ST_SI_MUL;
      ST_SI_MUL:    if (step) state_next = ST_RC_MUL;
      ST_RC_MUL:    if (step) state_next = ST_IC_MUL;
      ST_IC_MUL:    if (step) state_next = ST_GAIN_MUL;
      ST_GAIN_MUL:  if (step) state_next = ST_TERM_MUL;
      ST_TERM_MUL:  if (step) state_next = ST_RR_MUL;
      ST_RR_MUL:    if (step) state_next = ST_II_MUL;
      ST_II_MUL:    if (step) state_next = ST_IR_MUL;
      ST_IR_MUL:    if (step) state_next = ST_RI_MUL;
      ST_RI_MUL:    if (step) state_next = ST_WB;
      ST_WB:        if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_next = ST_AMP_DIV;
      op_start = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      issued <= 1'b0;
    end else if (op_start) begin
      issued <= 1'b1;
    end else if (step) begin
      issued <= 1'b0;
    end
  end

  // operand select
  always_comb begin
    mreq.start = op_start && is_mul;
    mreq.a = '0;
    mreq.b = '0;
    case (state)
      ST_PS_MUL: begin
        mreq.a = MUL_W'({2'b0, sample_period});
        mreq.b = MUL_W'(TWO_PI_Q29[31:0]);
      end
      ST_DEC_MUL: begin
        mreq.a = MUL_W'(freq);
        mreq.b = MUL_W'(pole_scale);
      end
      ST_PHASE_MUL: begin
        mreq.a = MUL_W'(freq);
        mreq.b = MUL_W'(sample_period);
      end
      ST_CI_MUL: begin
        mreq.a = MUL_W'(tb - ta);
        mreq.b = MUL_W'(frac);
      end
      ST_SI_MUL: begin
        mreq.a = MUL_W'(sb - sa);
        mreq.b = MUL_W'(frac);
      end
      ST_RC_MUL: begin
        mreq.a = MUL_W'(radius);
        mreq.b = MUL_W'(ci);
      end
      ST_IC_MUL: begin
        mreq.a = MUL_W'(radius);
        mreq.b = MUL_W'(si);
      end
      ST_GAIN_MUL: begin
        mreq.a = MUL_W'(amp);
        mreq.b = MUL_W'(inv_r);
      end
      ST_TERM_MUL: begin
        mreq.a = MUL_W'(gain);
        mreq.b = MUL_W'(samp);
      end
      ST_RR_MUL: begin
        mreq.a = MUL_W'(rc);
        mreq.b = MUL_W'(rs);
      end
      ST_II_MUL: begin
        mreq.a = MUL_W'(ic);
        mreq.b = MUL_W'(is);
      end
      ST_IR_MUL: begin
        mreq.a = MUL_W'(ic);
        mreq.b = MUL_W'(rs);
      end
      ST_RI_MUL: begin
        mreq.a = MUL_W'(rc);
        mreq.b = MUL_W'(is);
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_comb begin
    dreq.start = op_start && is_div;
    if (state == ST_PS_DIV) begin
      dreq.num = num;
      dreq.den = ps_den;
    end else begin
      dreq.num = 64'd1 << 33;
      dreq.den = DIV_DEN_W'(q_factor) + DIV_DEN_W'(AMP_ONE);
    end
  end

  rbf_serial_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  rbf_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // cosine ROM, quarter wave mirrored
  assign idx2 = idx - L'(QN);

  always_comb begin
    case (rd_cnt)
      3'd0:    rd_n = {1'b0, idx};
      3'd1:    rd_n = {1'b0, idx} + (L+1)'(1);
      3'd2:    rd_n = {1'b0, idx2};
      default: rd_n = {1'b0, idx2} + (L+1)'(1);
    endcase
    quad = rd_n[L:L-2];
    if (quad[2]) begin
      rom_addr = '0;
      rom_neg = 1'b0;
    end else begin
      rom_addr = quad[0] ? QA_W'(QN) - {1'b0, rd_n[L-3:0]} : {1'b0, rd_n[L-3:0]};
      rom_neg = quad[1] ^ quad[0];
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= QROM[rom_addr];
    neg_q <= rom_neg;
  end

  assign rd_val = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_ff @(posedge clk) begin
    if (rst || state != ST_TAB_RD) begin
      rd_cnt <= '0;
    end else begin
      rd_cnt <= rd_cnt + 3'd1;
    end
  end

  // configuration and derived coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      q_factor      <= '0;
      sample_period <= SP_RESET;
      amp           <= AMP_RESET;
      pole_scale    <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == CFG_Q_FACTOR) q_factor <= cfg_data;
      else sample_period <= cfg_data;
    end else begin
      if (state == ST_AMP_DIV && step) begin
        amp <= AMP_ONE - drsp.quo[17:0];
        if (q_factor == 32'd0) pole_scale <= '0;
      end
      if (state == ST_PS_DIV) begin
        if (ps_sat) pole_scale <= 32'hFFFFFFFF;
        else if (step) pole_scale <= drsp.quo;
      end
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      rs <= '0;
      is <= '0;
    end else if (state == ST_RI_MUL && step) begin
      rs <= nr;
      is <= sat32(40'((acc + prod) >>> 30));
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && !in_stall) begin
      samp <= input_sample;
      freq <= center_freq[24] ? 24'd0 : center_freq[23:0];
    end
    if (state == ST_TAB_RD) begin
      case (rd_cnt)
        3'd1:    ta <= rd_val;
        3'd2:    tb <= rd_val;
        3'd3:    sa <= rd_val;
        3'd4:    sb <= rd_val;
        default: ;
      endcase
    end
    if (step) begin
      case (state)
        ST_PS_MUL:    num <= prod[63:0];
        ST_DEC_MUL:   radius <= (pole_scale != 32'd0 && dec < 52'hFFFFFFFF) ?
                                (32'hFFFFFFFF - dec[31:0]) : 32'd0;
        ST_PHASE_MUL: begin
          idx  <= prod[39 -: L];
          frac <= prod[39-L -: 16];
        end
        ST_CI_MUL:    ci <= ta + 25'(prod >>> 16);
        ST_SI_MUL:    si <= sa + 25'(prod >>> 16);
        ST_RC_MUL:    rc <= 32'(prod >>> 25);
        ST_IC_MUL:    ic <= 32'(prod >>> 25);
        ST_GAIN_MUL:  gain <= prod[50:20];
        ST_TERM_MUL:  term <= 32'(prod >>> (SAMPLE_WIDTH - 1));
        ST_RR_MUL:    acc <= prod;
        ST_II_MUL:    nr <= sat32(40'(term) + 40'((acc - prod) >>> 30));
        ST_IR_MUL:    acc <= prod;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WB && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WB && (!out_valid || !out_stall)) begin
      real_out <= to_out(rs);
      imag_out <= to_out(is);
    end
  end

  `RBF_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == ST_DEC_MUL, "accepted item did not start")
  `RBF_ASSERT_NEXT(a_wb_loads, state == ST_WB && !out_valid, out_valid, "write-back lost a result")
  `RBF_ASSERT_NEXT(a_cfg_derive, cfg_hit, state == ST_AMP_DIV && !issued, "config write did not restart derive")

endmodule
